### sv/turn_signal_hazard_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// Turn signal hazard controller assertion macros
// Clocked property checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef TURN_SIGNAL_HAZARD_CONTROLLER_UNIT_DEFINES_SVH
`define TURN_SIGNAL_HAZARD_CONTROLLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define TSHCU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define TSHCU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TSHCU_ASSERT(lbl, clk, rst, prop, msg)
`define TSHCU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/tshcu_pkg.sv
// ----------------------------------------------------------------------------
// Turn signal hazard controller package
// Shared types, register indexes and timing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tshcu_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned HP_W   = 11;  // half period in ms, at most 2000
  localparam int unsigned CNT_W  = 5;   // one quotient bit per cycle

  localparam logic [TIME_W-1:0] HAZARD_WINDOW_MS = 32'd400;
  localparam logic [TIME_W-1:0] RESYNC_PERIOD_MS = 32'd3600000;
  localparam logic [HP_W-1:0]   DEFAULT_HALF_MS  = 11'd500;
  localparam logic [7:0]        BLINK_MIN        = 8'd10;
  localparam logic [7:0]        BLINK_MAX        = 8'd200;
  localparam logic [9:0]        MS_PER_SECOND    = 10'd1000;

  // Register indexes
  localparam logic [1:0] REG_FEATURE_ENABLE   = 2'd0;
  localparam logic [1:0] REG_BLINK_INTERVAL   = 2'd1;
  localparam logic [1:0] REG_AUTO_OFF_SECONDS = 2'd2;
  localparam logic [1:0] REG_HAS_LAMP_OUTPUTS = 2'd3;

  // Message direction codes
  localparam logic [1:0] DIR_LEFT   = 2'd0;
  localparam logic [1:0] DIR_RIGHT  = 2'd1;
  localparam logic [1:0] DIR_HAZARD = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [HP_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic quot_lsb;
  } div_status_t;

endpackage

`default_nettype wire

### sv/tshcu_div.sv
// ----------------------------------------------------------------------------
// Turn signal hazard controller divider
// Restoring divider, one quotient bit per cycle; reports the quotient LSB.
// ----------------------------------------------------------------------------
`default_nettype none

`include "turn_signal_hazard_controller_unit_defines.svh"

module tshcu_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire tshcu_pkg::div_req_t    req,
  output tshcu_pkg::div_status_t      status
);
  import tshcu_pkg::*;

  logic [HP_W-1:0]   rem;
  logic [TIME_W-1:0] dvd;
  logic [HP_W-1:0]   dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic              quot_lsb;

  logic [HP_W:0]     trial;
  logic              ge;

  assign trial = {rem, dvd[TIME_W-1]};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem      <= ge ? HP_W'(trial - {1'b0, dsr}) : trial[HP_W-1:0];
      dvd      <= {dvd[TIME_W-2:0], 1'b0};
      quot_lsb <= ge;
    end
  end

  assign status.busy     = busy;
  assign status.done     = done;
  assign status.quot_lsb = quot_lsb;

  `TSHCU_ASSERT(a_div_no_restart, clk, rst, req.start |-> !busy, "divider restarted while busy")
  `TSHCU_ASSERT(a_div_done_idle, clk, rst, done |-> !busy, "divider done while still busy")
  `TSHCU_ASSERT(a_div_start_busy, clk, rst, req.start |=> busy, "divider did not start")

endmodule

`default_nettype wire

### sv/turn_signal_hazard_controller_unit.sv
// ----------------------------------------------------------------------------
// Turn signal hazard controller
// Resolves left, right and hazard indication from request edges and blinks
// the lamps by phase against a shared epoch.
// ----------------------------------------------------------------------------
// Usage:
//   One tick item enters on the input channel (in_valid/in_ready) and one
//   result leaves on the output channel (out_valid/out_ready) for each.
//   in_ready is high only while the sequencer is idle. After a transfer the
//   block runs a compute step for edge detection, hazard resolution, auto
//   shut-off and resync. When a side is lit, lamps are fitted and the
//   feature is enabled and not suppressed, a divide step follows in the
//   restoring divider (32 quotient bits; bit 0 of (now - epoch) / half
//   period gives the blink phase). A final step loads the output register.
//   The next item is taken only once the sequencer is back in idle.
//   The output register holds a finished result while the next item is
//   taken; a stalled receiver holds the sequencer in its final step only.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   the user makes them while the block is idle; the block does not enforce it.
//   Reset clears all indication state and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "turn_signal_hazard_controller_unit_defines.svh"

module turn_signal_hazard_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // tick items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] now_ms,
  input  wire logic        left_request,
  input  wire logic        right_request,
  input  wire logic        local_origin,
  input  wire logic        resync_seen,
  input  wire logic        test_suppress,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             left_lamp,
  output logic             right_lamp,
  output logic             left_request_clear,
  output logic             right_request_clear,
  output logic             send_message,
  output logic             signal_on,
  output logic [1:0]       signal_direction
);
  import tshcu_pkg::*;

  // configuration registers
  logic        feature_enable;
  logic [7:0]  blink_interval_tenths;
  logic [15:0] auto_off_seconds;
  logic        has_lamp_outputs;

  // captured item
  logic [TIME_W-1:0] now_q;
  logic cl_q, cr_q, local_q, resync_q, suppress_q;

  // indication state
  logic last_left_req, last_right_req, left_on, right_active;
  logic [TIME_W-1:0] on_since_time, phase_epoch, left_start_time, right_start_time;
  logic originator_flag;
  logic [TIME_W-1:0] last_resync_time;
  logic left_lamp_level, right_lamp_level;
  logic res_clr_l, res_clr_r, res_send;

  // next values for the step
  logic last_left_req_next, last_right_req_next, left_on_next, right_active_next;
  logic [TIME_W-1:0] on_since_time_next, phase_epoch_next;
  logic [TIME_W-1:0] left_start_time_next, right_start_time_next;
  logic originator_flag_next;
  logic [TIME_W-1:0] last_resync_time_next;
  logic left_lamp_level_next, right_lamp_level_next;
  logic res_clr_l_next, res_clr_r_next, res_send_next;
  logic need_div;

  // step intermediates
  logic hazard_active, timing, l_up, r_up, l_dn, r_dn;
  logic [TIME_W-1:0] auto_limit;
  logic [HP_W-1:0]   half_ms;

  state_t      state;
  div_req_t    div_req;
  div_status_t div_st;

  tshcu_div u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .status (div_st)
  );

  assign in_ready   = (state == S_IDLE);
  assign auto_limit = TIME_W'({16'd0, auto_off_seconds} * {22'd0, MS_PER_SECOND});
  assign half_ms    = (blink_interval_tenths >= BLINK_MIN && blink_interval_tenths <= BLINK_MAX)
                    ? HP_W'({3'd0, blink_interval_tenths} * 11'd10) : DEFAULT_HALF_MS;

  // Resolve one tick; used only in the compute step.
  always_comb begin
    last_left_req_next    = last_left_req;
    last_right_req_next   = last_right_req;
    left_on_next          = left_on;
    right_active_next     = right_active;
    on_since_time_next    = on_since_time;
    phase_epoch_next      = phase_epoch;
    left_start_time_next  = left_start_time;
    right_start_time_next = right_start_time;
    originator_flag_next  = originator_flag;
    last_resync_time_next = last_resync_time;
    left_lamp_level_next  = left_lamp_level;
    right_lamp_level_next = right_lamp_level;
    res_clr_l_next        = 1'b0;
    res_clr_r_next        = 1'b0;
    res_send_next         = 1'b0;
    need_div              = 1'b0;
    hazard_active         = left_on && right_active;
    timing                = (on_since_time != '0) && (auto_off_seconds != '0) && !hazard_active
                            && (cl_q || cr_q);
    l_up                  = cl_q && !last_left_req;
    r_up                  = cr_q && !last_right_req;
    l_dn                  = !cl_q && last_left_req;
    r_dn                  = !cr_q && last_right_req;

    if (feature_enable && !suppress_q) begin
      if (timing && ((now_q - on_since_time) >= auto_limit)) begin
        // auto shut-off: drop both sides and clear both requests
        left_on_next          = 1'b0;
        right_active_next     = 1'b0;
        left_lamp_level_next  = 1'b0;
        right_lamp_level_next = 1'b0;
        last_left_req_next    = 1'b0;
        last_right_req_next   = 1'b0;
        on_since_time_next    = '0;
        res_clr_l_next        = 1'b1;
        res_clr_r_next        = 1'b1;
        res_send_next         = 1'b1;
      end else begin
        if (!timing) begin
          on_since_time_next = '0;
        end
        if (cl_q != last_left_req || cr_q != last_right_req) begin
          last_left_req_next  = cl_q;
          last_right_req_next = cr_q;
          if (l_up && r_up) begin
            left_on_next      = 1'b1;
            right_active_next = 1'b1;
          end else if (hazard_active && (l_dn || r_dn)) begin
            left_on_next      = 1'b0;
            right_active_next = 1'b0;
          end else if (r_up && left_on && !right_active) begin
            right_active_next = 1'b1;
            left_on_next      = ((now_q - left_start_time) <= HAZARD_WINDOW_MS);
          end else if (l_up && right_active && !left_on) begin
            left_on_next      = 1'b1;
            right_active_next = ((now_q - right_start_time) <= HAZARD_WINDOW_MS);
          end else if (l_up) begin
            left_on_next = 1'b1;
          end else if (l_dn) begin
            left_on_next = 1'b0;
          end else if (r_up) begin
            right_active_next = 1'b1;
          end else if (r_dn) begin
            right_active_next = 1'b0;
          end

          if (left_on_next && !left_on) begin
            left_start_time_next = now_q;
            on_since_time_next   = now_q;
            phase_epoch_next     = now_q;
          end
          if (right_active_next && !right_active) begin
            right_start_time_next = now_q;
            on_since_time_next    = now_q;
            phase_epoch_next      = now_q;
          end
          if (!left_on_next && left_on) begin
            left_lamp_level_next = 1'b0;
            last_left_req_next   = 1'b0;
            res_clr_l_next       = 1'b1;
          end
          if (!right_active_next && right_active) begin
            right_lamp_level_next = 1'b0;
            last_right_req_next   = 1'b0;
            res_clr_r_next        = 1'b1;
          end
          if (local_q) begin
            originator_flag_next = left_on_next || right_active_next;
            if (originator_flag_next) begin
              last_resync_time_next = now_q;
            end
            res_send_next = 1'b1;
          end
        end

        // blink stage: re-anchor the epoch, then hand the phase to the divider
        if (has_lamp_outputs && (left_on_next || right_active_next)) begin
          if (resync_q) begin
            phase_epoch_next = now_q;
          end
          if (originator_flag_next
              && ((now_q - last_resync_time_next) >= RESYNC_PERIOD_MS)) begin
            last_resync_time_next = now_q;
            phase_epoch_next      = now_q;
            res_send_next         = 1'b1;
          end
          need_div = 1'b1;
        end
      end
    end
  end

  assign div_req.start    = (state == S_CALC) && need_div;
  assign div_req.dividend = now_q - phase_epoch_next;
  assign div_req.divisor  = half_ms;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      feature_enable        <= 1'b0;
      blink_interval_tenths <= 8'd50;
      auto_off_seconds      <= 16'd0;
      has_lamp_outputs      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FEATURE_ENABLE:   feature_enable        <= cfg_data[0];
        REG_BLINK_INTERVAL:   blink_interval_tenths <= cfg_data[7:0];
        REG_AUTO_OFF_SECONDS: auto_off_seconds      <= cfg_data;
        REG_HAS_LAMP_OUTPUTS: has_lamp_outputs      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // hold the accepted item for the whole step
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_q      <= now_ms;
      cl_q       <= left_request;
      cr_q       <= right_request;
      local_q    <= local_origin;
      resync_q   <= resync_seen;
      suppress_q <= test_suppress;
    end
  end

  // sequencer and indication state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      last_left_req    <= 1'b0;
      last_right_req   <= 1'b0;
      left_on          <= 1'b0;
      right_active     <= 1'b0;
      on_since_time    <= '0;
      phase_epoch      <= '0;
      left_start_time  <= '0;
      right_start_time <= '0;
      originator_flag  <= 1'b0;
      last_resync_time <= '0;
      left_lamp_level  <= 1'b0;
      right_lamp_level <= 1'b0;
      res_clr_l        <= 1'b0;
      res_clr_r        <= 1'b0;
      res_send         <= 1'b0;
    end else begin
      // load a new result, or drop the one just transferred
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          last_left_req    <= last_left_req_next;
          last_right_req   <= last_right_req_next;
          left_on          <= left_on_next;
          right_active     <= right_active_next;
          on_since_time    <= on_since_time_next;
          phase_epoch      <= phase_epoch_next;
          left_start_time  <= left_start_time_next;
          right_start_time <= right_start_time_next;
          originator_flag  <= originator_flag_next;
          last_resync_time <= last_resync_time_next;
          left_lamp_level  <= left_lamp_level_next;
          right_lamp_level <= right_lamp_level_next;
          res_clr_l        <= res_clr_l_next;
          res_clr_r        <= res_clr_r_next;
          res_send         <= res_send_next;
          state            <= need_div ? S_DIV : S_EMIT;
        end
        S_DIV: begin
          // even quotient means the lamp is in its on half
          if (div_st.done) begin
            if (left_on) begin
              left_lamp_level <= !div_st.quot_lsb;
            end
            if (right_active) begin
              right_lamp_level <= !div_st.quot_lsb;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register; loaded when the final step hands over a result
  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      left_lamp           <= left_lamp_level && has_lamp_outputs;
      right_lamp          <= right_lamp_level && has_lamp_outputs;
      left_request_clear  <= res_clr_l;
      right_request_clear <= res_clr_r;
      send_message        <= res_send;
      signal_on           <= res_send && (left_on || right_active);
      if (!res_send) begin
        signal_direction <= DIR_LEFT;
      end else if (left_on && right_active) begin
        signal_direction <= DIR_HAZARD;
      end else if (right_active) begin
        signal_direction <= DIR_RIGHT;
      end else begin
        signal_direction <= DIR_LEFT;
      end
    end
  end

  `TSHCU_ASSERT(a_done_in_div, clk, rst, div_st.done |-> (state == S_DIV), "divider result outside divide step")
  `TSHCU_ASSERT(a_emit_loads, clk, rst, (state == S_EMIT && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE), "result not loaded")
  `TSHCU_ASSERT(a_quiet_msg, clk, rst, (out_valid && !send_message) |-> (!signal_on && signal_direction == DIR_LEFT), "message fields set without a message")
  `TSHCU_ASSERT(a_dir_legal, clk, rst, out_valid |-> (signal_direction != 2'd3), "illegal direction code")

endmodule

`default_nettype wire
